// ===== rtl/elpid_pkg.sv =====
package elpid_pkg;

  localparam int unsigned DivW  = 50;
  localparam int unsigned ProdW = 50;

  localparam logic signed [15:0] OneQ14     = 16'sd16384;
  localparam logic signed [15:0] HalfTurn   = 16'sd11520;
  localparam logic signed [15:0] FullTurn   = 16'sd23040;
  localparam logic [14:0]        DegrThrust = 15'd11468;
  localparam logic [31:0]        MsPerS     = 32'd1000;
  localparam logic [31:0]        NormDeg    = 32'd90;

  localparam logic [1:0] ModeDisarm   = 2'd0;
  localparam logic [1:0] ModeDirect   = 2'd1;
  localparam logic [1:0] ModeDegraded = 2'd2;
  localparam logic [1:0] ModeNormal   = 2'd3;

  localparam logic [2:0] RegGainProp  = 3'd0;
  localparam logic [2:0] RegGainInteg = 3'd1;
  localparam logic [2:0] RegGainDeriv = 3'd2;
  localparam logic [2:0] RegIntLimit  = 3'd3;
  localparam logic [2:0] RegLiftLimit = 3'd4;
  localparam logic [2:0] RegYawLimit  = 3'd5;
  localparam logic [2:0] RegDeadband  = 3'd6;

  typedef struct packed {
    logic                   start;
    logic                   by_const;
    logic                   by_ms;
    logic signed [DivW-1:0] num;
    logic [31:0]            den;
  } div_req_t;

endpackage

// ===== rtl/elpid_div.sv =====
module elpid_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  elpid_pkg::div_req_t                req_i,
  output logic                               done_o,
  output logic signed [elpid_pkg::DivW-1:0]  quot_o
);
  import elpid_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);
  // three 16-bit digits, each a digit step and a remainder step
  localparam int unsigned ConstSteps = 6;
  // ceil(2^36 / d), exact for every digit step below d * 2^16
  localparam logic [29:0] RecipMs  = 30'd68719477;
  localparam logic [29:0] RecipDeg = 30'd763549742;

  logic            busy_q, done_q, neg_q, cst_q, ms_q;
  logic [CntW-1:0] cnt_q;
  logic [32:0]     rem_q;
  logic [31:0]     den_q;
  logic [DivW-1:0] q_q;
  logic [15:0]     dig_q;
  logic [32:0]     rem_sh;
  logic            fits;
  logic [25:0]     part, back;
  logic [9:0]      dvs;
  logic [55:0]     prod;

  assign rem_sh = {rem_q[31:0], q_q[DivW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign part   = {rem_q[9:0], q_q[47:32]};
  assign dvs    = ms_q ? MsPerS[9:0] : NormDeg[9:0];
  assign prod   = 56'(part) * 56'(ms_q ? RecipMs : RecipDeg);
  assign back   = part - 26'(dig_q) * 26'(dvs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.by_const ? CntW'(ConstSteps) : CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[DivW-1];
      q_q   <= req_i.num[DivW-1] ? DivW'(-req_i.num) : req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
      cst_q <= req_i.by_const;
      ms_q  <= req_i.by_ms;
    end else if (busy_q) begin
      if (!cst_q) begin
        rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
        q_q   <= {q_q[DivW-2:0], fits};
      end else if (!cnt_q[0]) begin
        dig_q <= prod[51:36];
      end else begin
        rem_q <= {23'd0, back[9:0]};
        q_q   <= DivW'({q_q[31:0], dig_q});
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

// ===== rtl/envelope_limiter_pid_heading_hold.sv =====
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: raw_rudder, raw_thrust, raw_lift, yaw_rate, target_heading,
//                       current_heading, now_ms; tuser: mode, assisted
// m_axis    out  tdata: rudder, thrust, lift; tuser: armed
// cfg       in   write enable, register index, data
// An item without heading hold goes from decode to the done state, which registers the result once the output is free.
// In heading hold the 50-step division by dt for the derivative takes most of the time;
// the integral and final scalings run on the same divider, by digits.
// Reset clears the integral, previous error and last time; no clearing pass.
// Input is taken only when idle; a stalled result holds the last step.
module envelope_limiter_pid_heading_hold (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // raw_rudder, raw_thrust, raw_lift, yaw_rate,
                                        // target_heading, current_heading, now_ms
  input  logic [2:0]   s_axis_tuser_i,  // mode, assisted
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [47:0]  m_axis_tdata_o,  // rudder, thrust, lift
  output logic         m_axis_tuser_o,  // armed
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [29:0]  cfg_data_i
);
  import elpid_pkg::*;

  localparam logic [3:0] StIdle = 4'd0,  StDec = 4'd1,  StMed = 4'd2,  StInt = 4'd3,
                         StWd   = 4'd4,  StMi  = 4'd5,  StDi  = 4'd6,  StWi  = 4'd7,
                         StMp   = 4'd8,  StMg  = 4'd9,  StSd  = 4'd10, StWs  = 4'd11,
                         StDone = 4'd12;

  logic [3:0] st_q, st_d;

  logic [15:0] gp_q, gi_q, gd_q;
  logic [29:0] lim_q;
  logic [14:0] ll_q, yl_q, db_q;

  logic signed [15:0] rud_q, thr_q, lft_q, yaw_q;
  logic [14:0] tgt_q, cur_q;
  logic [1:0]  mode_q;
  logic        asst_q;
  logic [31:0] now_q;

  logic signed [31:0] isum_q;
  logic signed [15:0] prev_q, err_q;
  logic [31:0]        last_q, dt_q;
  logic signed [25:0] deriv_q;
  logic signed [ProdW-1:0] prod_q, s_q;

  logic signed [15:0] r_q;
  logic [14:0] t_q, l_q;
  logic        a_q;
  logic        ov_q;

  div_req_t div_req;
  logic     div_done;
  logic signed [DivW-1:0] quot;

  elpid_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quot_o(quot)
  );

  // decode
  logic signed [15:0] rud_c, e0, e1, e2, r_fast;
  logic [16:0] mag;
  logic degr, pid_go, stick_on;
  logic [14:0] ll_eff, tl;
  logic [16:0] ll7;
  logic [36:0] ll_prod;
  logic [16:0] ll_q0, ll_div;
  logic [20:0] ll_rem;
  logic signed [20:0] ycmp, ylc;
  logic [14:0] t_fast, l_fast;

  always_comb begin
    rud_c = rud_q > OneQ14 ? OneQ14 : (rud_q < -OneQ14 ? -OneQ14 : rud_q);
    mag   = rud_q[15] ? 17'(-$signed({rud_q[15], rud_q})) : {1'b0, rud_q};
    degr  = mode_q == ModeDegraded;
    ll_eff = ll_q > 15'd16384 ? 15'd16384 : ll_q;
    ll7    = 17'(ll_eff) * 17'd7;
    ll_prod = 37'(ll7) * 37'd104857;
    ll_q0   = ll_prod[36:20];
    ll_rem  = 21'(ll7) - 21'(ll_q0) * 21'd10;
    ll_div  = ll_rem >= 21'd10 ? ll_q0 + 17'd1 : ll_q0;
    tl   = degr ? DegrThrust : 15'd16384;
    ycmp = degr ? 21'(yaw_q) * 21'sd10 : 21'(yaw_q);
    ylc  = degr ? $signed(21'(yl_q) * 21'd7) : $signed(21'(yl_q));
    r_fast = rud_c;
    t_fast = '0;
    l_fast = '0;
    unique case (mode_q)
      ModeDisarm: r_fast = '0;
      ModeDirect: begin
        t_fast = thr_q < 0 ? '0 : (thr_q > OneQ14 ? 15'd16384 : thr_q[14:0]);
        l_fast = lft_q < 0 ? '0 : (lft_q > OneQ14 ? 15'd16384 : lft_q[14:0]);
      end
      default: begin
        if (ycmp > ylc && rud_c > 0) r_fast = '0;
        if (ycmp < -ylc && rud_c < 0) r_fast = '0;
        t_fast = thr_q < 0 ? '0 : ($signed({1'b0, thr_q}) > $signed({2'b0, tl})
                 ? tl : thr_q[14:0]);
        l_fast = lft_q < 0 ? '0 :
                 ($signed({1'b0, lft_q}) > $signed({2'b0, (degr ? ll_div[14:0] : ll_eff)})
                 ? (degr ? ll_div[14:0] : ll_eff) : lft_q[14:0]);
      end
    endcase
    stick_on = mag > {2'b0, db_q};
    pid_go   = mode_q[1] && asst_q && !stick_on;
    e0 = $signed({1'b0, tgt_q}) - $signed({1'b0, cur_q});
    e1 = e0 > HalfTurn ? e0 - FullTurn : e0;
    e2 = e1 < -HalfTurn ? e1 + FullTurn : e1;
  end

  // shared multiplier operands
  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  always_comb begin
    mul_a = 17'(err_q);
    mul_b = $signed({1'b0, dt_q});
    unique case (st_q)
      StMi:    begin mul_a = $signed({1'b0, gi_q}); mul_b = 33'(isum_q);  end
      StMp:    begin mul_a = $signed({1'b0, gp_q}); mul_b = 33'(err_q);   end
      StMg:    begin mul_a = $signed({1'b0, gd_q}); mul_b = 33'(deriv_q); end
      default: ;
    endcase
  end

  logic signed [ProdW-1:0] acc, lim_s, s_sum;
  logic signed [16:0] diff;
  logic signed [15:0] r_pid;
  always_comb begin
    acc   = ProdW'(isum_q) + prod_q;
    lim_s = $signed({{(ProdW-30){1'b0}}, lim_q});
    diff  = 17'(err_q) - 17'(prev_q);
    s_sum = s_q + prod_q;
    r_pid = quot > DivW'(OneQ14) ? OneQ14 :
            (quot < -DivW'(OneQ14) ? -OneQ14 : quot[15:0]);
    div_req.start    = 1'b0;
    div_req.by_const = 1'b0;
    div_req.by_ms    = 1'b0;
    div_req.num      = DivW'(diff) * DivW'(MsPerS);
    div_req.den      = dt_q;
    unique case (st_q)
      StInt: div_req.start = dt_q != '0;
      StDi: begin
        div_req.start    = 1'b1;
        div_req.by_const = 1'b1;
        div_req.by_ms    = 1'b1;
        div_req.num      = prod_q;
      end
      StSd: begin
        div_req.start    = 1'b1;
        div_req.by_const = 1'b1;
        div_req.num      = s_sum;
      end
      default: ;
    endcase
  end

  logic out_free;
  assign out_free = !ov_q || m_axis_tready_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (s_axis_tvalid_i) st_d = StDec;
      StDec:  st_d = pid_go ? StMed : StDone;
      StMed:  st_d = StInt;
      StInt:  st_d = dt_q != '0 ? StWd : StMi;
      StWd:   if (div_done) st_d = StMi;
      StMi:   st_d = StDi;
      StDi:   st_d = StWi;
      StWi:   if (div_done) st_d = StMp;
      StMp:   st_d = StMg;
      StMg:   st_d = StSd;
      StSd:   st_d = StWs;
      StWs:   if (div_done) st_d = StDone;
      StDone: if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      ov_q   <= 1'b0;
      gp_q   <= 16'd256;
      gi_q   <= '0;
      gd_q   <= '0;
      lim_q  <= 30'd1000000;
      ll_q   <= 15'd16384;
      yl_q   <= 15'd1600;
      db_q   <= 15'd820;
      isum_q <= '0;
      prev_q <= '0;
      last_q <= '0;
    end else begin
      st_q <= st_d;
      if (m_axis_tready_i) ov_q <= 1'b0;
      if (st_q == StDone && out_free) ov_q <= 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegGainProp:  gp_q  <= cfg_data_i[15:0];
          RegGainInteg: gi_q  <= cfg_data_i[15:0];
          RegGainDeriv: gd_q  <= cfg_data_i[15:0];
          RegIntLimit:  lim_q <= cfg_data_i;
          RegLiftLimit: ll_q  <= cfg_data_i[14:0];
          RegYawLimit:  yl_q  <= cfg_data_i[14:0];
          RegDeadband:  db_q  <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (st_q == StDec && mode_q[1] && asst_q) begin
        last_q <= now_q;
        if (stick_on) begin
          isum_q <= '0;
          prev_q <= '0;
        end
      end
      if (st_q == StInt) begin
        isum_q <= acc > lim_s ? 32'(lim_s) : (acc < -lim_s ? 32'(-lim_s) : 32'(acc));
        prev_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && s_axis_tvalid_i) begin
      rud_q  <= s_axis_tdata_i[15:0];
      thr_q  <= s_axis_tdata_i[31:16];
      lft_q  <= s_axis_tdata_i[47:32];
      yaw_q  <= s_axis_tdata_i[63:48];
      tgt_q  <= s_axis_tdata_i[78:64];
      cur_q  <= s_axis_tdata_i[93:79];
      now_q  <= s_axis_tdata_i[125:94];
      mode_q <= s_axis_tuser_i[1:0];
      asst_q <= s_axis_tuser_i[2];
    end
    if (st_q == StDec) begin
      r_q   <= (mode_q[1] && asst_q) ? rud_c : r_fast;
      t_q   <= t_fast;
      l_q   <= l_fast;
      a_q   <= mode_q != ModeDisarm;
      err_q <= e2;
      dt_q  <= now_q - last_q;
    end
    if (st_q == StMed || st_q == StMi || st_q == StMp || st_q == StMg)
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    if (st_q == StInt && dt_q == '0) deriv_q <= '0;
    if (st_q == StWd && div_done) deriv_q <= quot[25:0];
    if (st_q == StWi && div_done) s_q <= quot;
    if (st_q == StMg) s_q <= s_sum;
    if (st_q == StWs && div_done) r_q <= r_pid;
    if (st_q == StDone && out_free) begin
      m_axis_tdata_o <= {2'b0, l_q, t_q, r_q};
      m_axis_tuser_o <= a_q;
    end
  end

  assign s_axis_tready_o = st_q == StIdle;
  assign m_axis_tvalid_o = ov_q;

  a_rud_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[15:0]) <= OneQ14 &&
                         $signed(m_axis_tdata_o[15:0]) >= -OneQ14))
    else $error("rudder out of range");
  a_disarm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tdata_o == '0)
    else $error("disarmed result not zero");
  a_lim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[30:16] <= 15'd16384 &&
                         m_axis_tdata_o[45:31] <= 15'd16384))
    else $error("thrust or lift out of range");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == StWd || st_q == StWi || st_q == StWs))
    else $error("divider finished outside a wait state");

endmodule
